FILE: rtl/pdec_pkg.sv
package pdec_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CASE_MASK = 8'hDF;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_DIG  = 2'd2
  } phase_e;

  // Decoded bytes of one input transaction, oldest in slot 0
  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [1:0]             cnt;
    logic                   last;
  } pdec_group_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pdec_qstat_t;

  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= CH_0) && (b <= CH_9)) || ((b >= CH_UA) && (b <= CH_UF)) ||
           ((b >= CH_LA) && (b <= CH_LF));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] t;
    if (b >= CH_UA) begin
      t = ((b & CASE_MASK) - CH_UA) + HEX_TEN;
    end else begin
      t = b - CH_0;
    end
    return t[3:0];
  endfunction

endpackage

FILE: rtl/pdec_front.sv
module pdec_front
  import pdec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_byte_i,
  input  logic        s_last_i,
  output logic        push_o,
  output pdec_group_t grp_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       p2s_q;
  logic       fire;
  logic       b_hex;
  logic       do_plain;
  logic [7:0] plain_byte;
  logic [1:0] n;

  assign fire  = s_valid_i && s_ready_i;
  assign b_hex = is_hex(s_byte_i);
  assign plain_byte = ((s_byte_i == CH_PLUS) && p2s_q) ? CH_SPACE : s_byte_i;

  always_comb begin
    grp_o    = '0;
    n        = '0;
    phase_d  = phase_q;
    held_d   = held_q;
    do_plain = 1'b0;

    unique case (phase_q)
      PH_ESC: begin
        if (b_hex) begin
          held_d  = s_byte_i;
          phase_d = PH_DIG;
        end else begin
          phase_d = PH_TEXT;
          grp_o.data[n] = CH_PCT;
          n = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_DIG: begin
        phase_d = PH_TEXT;
        if (b_hex) begin
          grp_o.data[n] = {hex_val(held_q), hex_val(s_byte_i)};
          n = n + 2'd1;
        end else begin
          grp_o.data[n] = CH_PCT;
          n = n + 2'd1;
          grp_o.data[n] = held_q;
          n = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        phase_d  = PH_TEXT;
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (s_byte_i == CH_PCT) begin
        phase_d = PH_ESC;
      end else begin
        grp_o.data[n] = plain_byte;
        n = n + 2'd1;
      end
    end

    // Flush an open escape at the end of the string
    if (s_last_i) begin
      if (phase_d == PH_ESC) begin
        grp_o.data[n] = CH_PCT;
        n = n + 2'd1;
      end else if (phase_d == PH_DIG) begin
        grp_o.data[n] = CH_PCT;
        n = n + 2'd1;
        grp_o.data[n] = held_d;
        n = n + 2'd1;
      end
      phase_d = PH_TEXT;
    end

    grp_o.cnt  = n;
    grp_o.last = s_last_i;
  end

  // Drop transactions that decode to nothing
  assign push_o = fire && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      held_q  <= '0;
      p2s_q   <= 1'b1;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
      if (cfg_we_i) begin
        p2s_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: rtl/pdec_fifo.sv
module pdec_fifo
  import pdec_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pdec_group_t push_grp_i,
  input  logic        pop_i,
  output pdec_group_t head_o,
  output pdec_qstat_t stat_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  pdec_group_t   mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == Full);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/pdec_back.sv
module pdec_back
  import pdec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pdec_group_t head_i,
  input  pdec_qstat_t stat_i,
  input  logic        m_ready_i,
  output logic        m_valid_o,
  output logic [7:0]  m_byte_o,
  output logic        m_run_end_o,
  output logic        m_str_end_o,
  output logic        pop_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign m_valid_o   = !stat_i.empty;
  assign fire        = m_valid_o && m_ready_i;
  assign m_run_end_o = (idx_q == (head_i.cnt - 2'd1));
  assign m_str_end_o = m_run_end_o && head_i.last;
  assign pop_o       = fire && m_run_end_o;

  always_comb begin
    case (idx_q)
      2'd0:    m_byte_o = head_i.data[0];
      2'd1:    m_byte_o = head_i.data[1];
      default: m_byte_o = head_i.data[2];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = m_run_end_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

FILE: rtl/percent_decoder_stream_core.sv
// Percent decoder for URL and CGI strings, one encoded byte per transaction.
// Slave channel: tdata carries the encoded byte, tlast marks the last byte of
// the string. Master channel: tdata carries one decoded byte, tuser is high on
// the last byte produced by one input transaction, tlast on the final decoded
// byte of the string. An input decodes to zero, one, two or three bytes.
// cfg_we_i/cfg_wdata_i write the plus-to-space flag (1 after reset); write it
// only while the block is idle.
// A decoded group pushed into an empty queue is registered and offered on the
// master side in the next cycle. Throughput: one input per cycle while each
// input yields at most one byte and the queue is not full; the master side
// delivers one byte per cycle while m_axis_tready_i is high. The queue between
// the decoder and the serialiser holds QUEUE_DEPTH decoded groups.
// Reset clears the escape state and the queue and sets the flag to CGI mode. When the
// receiver stalls, the current byte holds and the queue fills; s_axis_tready_o
// falls once it is full and rises again as groups drain.
module percent_decoder_stream_core
  import pdec_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tuser_o,  // [0] run_end
  output logic       m_axis_tlast_o
);

  pdec_group_t grp, head;
  pdec_qstat_t qstat;
  logic        push, pop;

  assign s_axis_tready_o = !qstat.full;

  pdec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_i   (s_axis_tready_o),
    .s_byte_i    (s_axis_tdata_i),
    .s_last_i    (s_axis_tlast_i),
    .push_o      (push),
    .grp_o       (grp)
  );

  pdec_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_grp_i (grp),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  pdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_byte_o    (m_axis_tdata_o),
    .m_run_end_o (m_axis_tuser_o),
    .m_str_end_o (m_axis_tlast_o),
    .pop_o       (pop)
  );

  a_str_end_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o)
    else $error("string end without run end");

  a_full_means_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> m_axis_tvalid_o)
    else $error("queue full but nothing offered");

  a_head_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (head.cnt != 2'd0))
    else $error("empty group at queue head");

  a_push_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (grp.cnt != 2'd0))
    else $error("empty group pushed");

endmodule
